### rtl/core/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cic_pkg.sv
`default_nettype none

package cic_pkg;

  localparam int NUM_CHIPS_DEF = 2;
  localparam int CHIP_W        = 3;

  localparam logic [2:0] KIND_WRITE = 3'd0;
  localparam logic [2:0] KIND_READ  = 3'd1;
  localparam logic [2:0] KIND_LINE  = 3'd2;
  localparam logic [2:0] KIND_ACK   = 3'd3;
  localparam logic [2:0] KIND_QUERY = 3'd4;

  localparam logic [7:0] CALL_OPCODE = 8'hcd;

  typedef struct packed {
    logic       hit;
    logic [2:0] chip;
    logic [2:0] level;
  } res_t;

  // First set bit of req, searching upwards from base with wrap; base if none.
  function automatic logic [2:0] rot_first(input logic [7:0] req, input logic [2:0] base);
    logic [15:0] dbl;
    logic [7:0]  rot;
    logic [2:0]  off;
    logic        found;
    dbl   = {req, req} >> base;
    rot   = dbl[7:0];
    off   = '0;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!found && rot[i]) begin
        off   = 3'(i);
        found = 1'b1;
      end
    end
    return base + off;
  endfunction

endpackage

`default_nettype wire

### rtl/core/cic_resolver.sv
`default_nettype none

module cic_resolver #(
  parameter int NUM_CHIPS = cic_pkg::NUM_CHIPS_DEF
) (
  input  wire logic [7:0] mr     [NUM_CHIPS],
  input  wire logic [7:0] rr     [NUM_CHIPS],
  input  wire logic [7:0] isr    [NUM_CHIPS],
  input  wire logic [2:0] rb     [NUM_CHIPS],
  input  wire logic [7:0] iw3    [NUM_CHIPS],
  input  wire logic [7:0] iw4    [NUM_CHIPS],
  input  wire logic [7:0] ocw    [NUM_CHIPS],
  output cic_pkg::res_t   res
);

  typedef enum logic [1:0] {
    ST_STOP,
    ST_CONT,
    ST_HIT
  } chip_st_t;

  chip_st_t   st  [NUM_CHIPS];
  logic [2:0] lvl [NUM_CHIPS];
  logic [7:0] slv [NUM_CHIPS];

  for (genvar g = 0; g < NUM_CHIPS; g++) begin : g_chip
    logic       master;
    logic [7:0] req;
    logic [7:0] req_sv;
    logic [7:0] bit_sel;

    if (g + 1 < NUM_CHIPS) begin : g_slave
      assign slv[g] = (|(rr[g+1] & ~mr[g+1])) ? (8'd1 << iw3[g+1][2:0]) : 8'd0;
    end else begin : g_last
      assign slv[g] = 8'd0;
    end

    assign master  = iw4[g][4];
    assign req     = (rr[g] | (master ? slv[g] : 8'd0)) & ~mr[g];
    assign req_sv  = ocw[g][5] ? req : (req | isr[g]);
    assign lvl[g]  = cic_pkg::rot_first(req_sv, rb[g]);
    assign bit_sel = 8'd1 << lvl[g];

    always_comb begin
      priority if (req == 8'd0) begin
        st[g] = ST_STOP;
      end else if (master && (|(iw3[g] & bit_sel))) begin
        st[g] = ST_CONT;
      end else if (|(isr[g] & bit_sel)) begin
        st[g] = ST_STOP;
      end else begin
        st[g] = ST_HIT;
      end
    end
  end

  // First chip that does not pass on to its slave decides.
  always_comb begin
    res = '0;
    for (int i = NUM_CHIPS - 1; i >= 0; i--) begin
      if (st[i] != ST_CONT) begin
        res.hit   = (st[i] == ST_HIT);
        res.chip  = 3'(i);
        res.level = lvl[i];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/cascaded_interrupt_controller.sv
// Cascadable 8259-style interrupt controller.
// A transaction accepted into the input register has its result registered
// when it advances, i.e. while the result register is empty or being taken.
// Throughput: one transaction per cycle unless results stall; state update and
// priority resolution are combinational between input and result registers.
// Reset (synchronous, rst_n low): masks all ones; chip/pending/valid state zero.
`default_nettype none

module cascaded_interrupt_controller #(
  parameter int NUM_CHIPS = cic_pkg::NUM_CHIPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic [3:0]  in_port_addr,
  input  wire logic [7:0]  in_write_data,
  input  wire logic [5:0]  in_irq_id,
  input  wire logic        in_line_level,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [7:0]  out_read_data,
  output      logic [23:0] out_vector,
  output      logic        out_intr_line
);

  logic       s1_valid_r;
  logic [2:0] s1_kind_r;
  logic [3:0] s1_addr_r;
  logic [7:0] s1_data_r;
  logic [5:0] s1_id_r;
  logic       s1_level_r;
  logic       adv;

  logic [7:0] mr_r  [NUM_CHIPS];
  logic [7:0] rr_r  [NUM_CHIPS];
  logic [7:0] isr_r [NUM_CHIPS];
  logic [2:0] rb_r  [NUM_CHIPS];
  logic [7:0] iw1_r [NUM_CHIPS];
  logic [7:0] iw2_r [NUM_CHIPS];
  logic [7:0] iw3_r [NUM_CHIPS];
  logic [7:0] iw4_r [NUM_CHIPS];
  logic [7:0] ocw_r [NUM_CHIPS];
  logic [2:0] exp_r [NUM_CHIPS];

  logic [7:0] mr_nxt  [NUM_CHIPS];
  logic [7:0] rr_nxt  [NUM_CHIPS];
  logic [7:0] isr_nxt [NUM_CHIPS];
  logic [2:0] rb_nxt  [NUM_CHIPS];
  logic [7:0] iw1_nxt [NUM_CHIPS];
  logic [7:0] iw2_nxt [NUM_CHIPS];
  logic [7:0] iw3_nxt [NUM_CHIPS];
  logic [7:0] iw4_nxt [NUM_CHIPS];
  logic [7:0] ocw_nxt [NUM_CHIPS];
  logic [2:0] exp_nxt [NUM_CHIPS];

  logic [2:0] pend_chip_r, pend_chip_nxt;
  logic [2:0] pend_lvl_r, pend_lvl_nxt;
  logic       intr_r, intr_nxt;

  logic        out_valid_r;
  logic [7:0]  out_rd_r;
  logic [23:0] out_vec_r;
  logic        out_intr_r;

  logic [2:0]  wr_chip;
  logic [2:0]  line_chip;
  logic [7:0]  line_bit;
  logic [7:0]  ack_bit;
  logic [7:0]  ack_sl;
  logic        ack_ok;
  logic        run_res;
  logic [7:0]  rd;
  logic [23:0] vec;
  logic [15:0] call_addr;
  logic [7:0]  d;
  logic [2:0]  eoi_lvl;
  cic_pkg::res_t res;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_kind_r  <= in_kind;
      s1_addr_r  <= in_port_addr;
      s1_data_r  <= in_write_data;
      s1_id_r    <= in_irq_id;
      s1_level_r <= in_line_level;
    end
  end

  assign wr_chip   = s1_addr_r[3:1];
  assign line_chip = s1_id_r[5:3];
  assign line_bit  = 8'd1 << s1_id_r[2:0];
  assign ack_bit   = 8'd1 << pend_lvl_r;
  assign ack_ok    = {1'b0, pend_chip_r} < 4'(NUM_CHIPS);

  always_comb begin
    rd        = '0;
    vec       = '0;
    ack_sl    = '0;
    call_addr = '0;
    run_res   = 1'b0;
    d         = s1_data_r;
    eoi_lvl   = '0;

    // Reads and the acknowledge vector use the state before this transaction.
    for (int i = 0; i < NUM_CHIPS; i++) begin
      if (s1_kind_r == cic_pkg::KIND_READ && wr_chip == 3'(i)) begin
        rd = s1_addr_r[0] ? mr_r[i] : (ocw_r[i][0] ? isr_r[i] : rr_r[i]);
      end
      if (s1_kind_r == cic_pkg::KIND_QUERY && line_chip == 3'(i)) begin
        rd = {7'd0, rr_r[i][s1_id_r[2:0]]};
      end
      if (s1_kind_r == cic_pkg::KIND_ACK && pend_chip_r == 3'(i)) begin
        ack_sl = 8'd1 << iw3_r[i][2:0];
        if (iw4_r[i][0]) begin
          vec = {16'd0, (iw2_r[i] & 8'hf8) | {5'd0, pend_lvl_r}};
        end else begin
          if (iw1_r[i][2]) begin
            call_addr = {iw2_r[i], (iw1_r[i] & 8'he0) | {3'd0, pend_lvl_r, 2'd0}};
          end else begin
            call_addr = {iw2_r[i], (iw1_r[i] & 8'hc0) | {2'd0, pend_lvl_r, 3'd0}};
          end
          vec = {call_addr, cic_pkg::CALL_OPCODE};
        end
      end
    end

    for (int i = 0; i < NUM_CHIPS; i++) begin
      mr_nxt[i]  = mr_r[i];
      rr_nxt[i]  = rr_r[i];
      isr_nxt[i] = isr_r[i];
      rb_nxt[i]  = rb_r[i];
      iw1_nxt[i] = iw1_r[i];
      iw2_nxt[i] = iw2_r[i];
      iw3_nxt[i] = iw3_r[i];
      iw4_nxt[i] = iw4_r[i];
      ocw_nxt[i] = ocw_r[i];
      exp_nxt[i] = exp_r[i];

      unique case (s1_kind_r)
        cic_pkg::KIND_WRITE: begin
          if (wr_chip == 3'(i)) begin
            if (s1_addr_r[0]) begin
              run_res = 1'b1;
              priority if (exp_r[i][0]) begin
                iw2_nxt[i]    = d;
                exp_nxt[i][0] = 1'b0;
              end else if (exp_r[i][1]) begin
                iw3_nxt[i]    = d;
                exp_nxt[i][1] = 1'b0;
              end else if (exp_r[i][2]) begin
                iw4_nxt[i]    = d;
                exp_nxt[i][2] = 1'b0;
              end else begin
                mr_nxt[i] = d;
              end
            end else if (d[4]) begin
              run_res    = 1'b1;
              iw1_nxt[i] = d;
              exp_nxt[i] = {d[0], ~d[1], 1'b1};
              rr_nxt[i]  = '0;
              isr_nxt[i] = '0;
              mr_nxt[i]  = '0;
              rb_nxt[i]  = '0;
              if (!d[0]) begin
                iw4_nxt[i] = '0;
              end
              ocw_nxt[i] = '0;
            end else if (d[3]) begin
              run_res    = 1'b1;
              ocw_nxt[i] = {d[7:6], (d[6] ? d[5] : ocw_r[i][5]), d[4:1],
                            (d[1] ? d[0] : ocw_r[i][0])};
            end else if (d[6] || isr_r[i] != 8'd0) begin
              run_res = 1'b1;
              eoi_lvl = d[6] ? d[2:0] : cic_pkg::rot_first(isr_r[i], rb_r[i]);
              if (d[7]) begin
                rb_nxt[i] = eoi_lvl + 3'd1;
              end
              if (d[5]) begin
                isr_nxt[i] = isr_r[i] & ~(8'd1 << eoi_lvl);
              end
            end
          end
        end
        cic_pkg::KIND_LINE: begin
          if (line_chip == 3'(i)) begin
            if (s1_level_r) begin
              rr_nxt[i] = rr_r[i] | line_bit;
              run_res   = 1'b1;
            end else if (iw1_r[i][3]) begin
              rr_nxt[i] = rr_r[i] & ~line_bit;
              run_res   = 1'b1;
            end
          end
        end
        cic_pkg::KIND_ACK: begin
          run_res = ack_ok;
          if (pend_chip_r == 3'(i)) begin
            isr_nxt[i] = iw4_r[i][1] ? (isr_r[i] & ~ack_bit) : (isr_r[i] | ack_bit);
            rr_nxt[i]  = rr_r[i] & ~ack_bit;
          end
          if ({1'b0, pend_chip_r} == 4'(i + 1)) begin
            isr_nxt[i] = isr_r[i] | ack_sl;
            rr_nxt[i]  = rr_r[i] & ~ack_sl;
          end
        end
        default: begin
        end
      endcase
    end
  end

  cic_resolver #(
    .NUM_CHIPS(NUM_CHIPS)
  ) u_resolver (
    .mr  (mr_nxt),
    .rr  (rr_nxt),
    .isr (isr_nxt),
    .rb  (rb_nxt),
    .iw3 (iw3_nxt),
    .iw4 (iw4_nxt),
    .ocw (ocw_nxt),
    .res (res)
  );

  always_comb begin
    pend_chip_nxt = pend_chip_r;
    pend_lvl_nxt  = pend_lvl_r;
    intr_nxt      = intr_r;
    if (run_res) begin
      intr_nxt = res.hit;
      if (res.hit) begin
        pend_chip_nxt = res.chip;
        pend_lvl_nxt  = res.level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHIPS; i++) begin
        mr_r[i]  <= 8'hff;
        rr_r[i]  <= '0;
        isr_r[i] <= '0;
        rb_r[i]  <= '0;
        iw1_r[i] <= '0;
        iw2_r[i] <= '0;
        iw3_r[i] <= '0;
        iw4_r[i] <= '0;
        ocw_r[i] <= '0;
        exp_r[i] <= '0;
      end
      pend_chip_r <= '0;
      pend_lvl_r  <= '0;
      intr_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        for (int i = 0; i < NUM_CHIPS; i++) begin
          mr_r[i]  <= mr_nxt[i];
          rr_r[i]  <= rr_nxt[i];
          isr_r[i] <= isr_nxt[i];
          rb_r[i]  <= rb_nxt[i];
          iw1_r[i] <= iw1_nxt[i];
          iw2_r[i] <= iw2_nxt[i];
          iw3_r[i] <= iw3_nxt[i];
          iw4_r[i] <= iw4_nxt[i];
          ocw_r[i] <= ocw_nxt[i];
          exp_r[i] <= exp_nxt[i];
        end
        pend_chip_r <= pend_chip_nxt;
        pend_lvl_r  <= pend_lvl_nxt;
        intr_r      <= intr_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rd_r   <= rd;
      out_vec_r  <= vec;
      out_intr_r <= intr_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_rd_r;
  assign out_vector    = out_vec_r;
  assign out_intr_line = out_intr_r;

`include "assert_macros.svh"

  `ASSERT_IMPL(a_pend_in_range, 1'b1, {1'b0, pend_chip_r} < 4'(NUM_CHIPS), "pending chip out of range")
  `ASSERT_NEXT(a_vec_ack_only, adv && s1_kind_r != cic_pkg::KIND_ACK, out_vec_r == 24'd0, "vector on non-acknowledge transaction")
  `ASSERT_NEXT(a_out_drain, out_valid_r && out_ready && !adv, !out_valid_r, "result not released after hand-off")

endmodule

`default_nettype wire

### tb/cic_checker.sv
module cic_checker #(
  parameter int NUM_CHIPS = cic_pkg::NUM_CHIPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [3:0]  in_port_addr,
  input  logic [7:0]  in_write_data,
  input  logic [5:0]  in_irq_id,
  input  logic        in_line_level,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_read_data,
  input  logic [23:0] out_vector,
  input  logic        out_intr_line,
  output int          fails,
  output int          waiting
);

  typedef struct packed {
    logic [7:0]  rdata;
    logic [23:0] vec;
    logic        intr;
  } bus_reply_t;

  bus_reply_t due_replies[$];

  logic [7:0] irq_mask[NUM_CHIPS];
  logic [7:0] irq_req[NUM_CHIPS];
  logic [7:0] in_service[NUM_CHIPS];
  logic [2:0] prio_base[NUM_CHIPS];
  logic [7:0] icw1[NUM_CHIPS];
  logic [7:0] icw2[NUM_CHIPS];
  logic [7:0] icw3[NUM_CHIPS];
  logic [7:0] icw4[NUM_CHIPS];
  logic [7:0] ocw3[NUM_CHIPS];
  logic [2:0] init_expect[NUM_CHIPS];
  logic [2:0] ack_chip;
  logic [2:0] ack_level;
  logic       cpu_irq;

  function automatic logic [2:0] first_from(input logic [7:0] bits, input logic [2:0] start);
    logic [2:0] lvl;
    lvl = start;
    for (int i = 0; i < 8; i++) begin
      if (!bits[lvl]) lvl = lvl + 3'd1;
    end
    return lvl;
  endfunction

  // Walk the chain from chip 0; a master that picks its slave input hands on to the next chip.
  function automatic void arbitrate();
    logic [7:0] req;
    logic [2:0] lvl;
    logic       master;
    logic       found;
    logic       stop;
    found = 1'b0;
    stop  = 1'b0;
    for (int c = 0; c < NUM_CHIPS && !stop; c++) begin
      req    = irq_req[c];
      master = icw4[c][4];
      if (c + 1 < NUM_CHIPS && master && (irq_req[c+1] & ~irq_mask[c+1]) != 8'd0)
        req[icw3[c+1][2:0]] = 1'b1;
      req = req & ~irq_mask[c];
      if (req == 8'd0) begin
        stop = 1'b1;
      end else begin
        if (!ocw3[c][5]) req = req | in_service[c];
        lvl = first_from(req, prio_base[c]);
        if (!(icw3[c][lvl] && master)) begin
          stop = 1'b1;
          if (!in_service[c][lvl]) begin
            ack_chip  = 3'(c);
            ack_level = lvl;
            found     = 1'b1;
          end
        end
      end
    end
    cpu_irq = found;
  endfunction

  function automatic bus_reply_t apply_event(input logic [2:0] kind, input logic [3:0] addr,
                                             input logic [7:0] d, input logic [5:0] id,
                                             input logic lv);
    bus_reply_t r;
    int         c;
    logic [2:0] lvl;
    logic [2:0] pin;
    logic [7:0] w;
    logic [7:0] low_addr;
    logic       skip;
    r = '0;
    case (kind)
      cic_pkg::KIND_WRITE: begin
        c    = int'(addr[3:1]);
        w    = d;
        skip = 1'b0;
        if (c < NUM_CHIPS) begin
          if (addr[0]) begin
            if (init_expect[c][0]) begin
              icw2[c] = w;
              init_expect[c][0] = 1'b0;
            end else if (init_expect[c][1]) begin
              icw3[c] = w;
              init_expect[c][1] = 1'b0;
            end else if (init_expect[c][2]) begin
              icw4[c] = w;
              init_expect[c][2] = 1'b0;
            end else begin
              irq_mask[c] = w;
            end
          end else if (w[4]) begin
            icw1[c]        = w;
            init_expect[c] = {w[0], ~w[1], 1'b1};
            irq_req[c]     = '0;
            in_service[c]  = '0;
            irq_mask[c]    = '0;
            prio_base[c]   = '0;
            if (!w[0]) icw4[c] = '0;
            ocw3[c] = '0;
          end else if (w[3]) begin
            if (!w[1]) w[0] = ocw3[c][0];
            if (!w[6]) w[5] = ocw3[c][5];
            ocw3[c] = w;
          end else begin
            lvl = w[2:0];
            if (!w[6]) begin
              if (in_service[c] == 8'd0) skip = 1'b1;
              else lvl = first_from(in_service[c], prio_base[c]);
            end
            if (!skip) begin
              if (w[7]) prio_base[c] = lvl + 3'd1;
              if (w[5]) in_service[c][lvl] = 1'b0;
            end
          end
          if (!skip) arbitrate();
        end
      end
      cic_pkg::KIND_READ: begin
        c = int'(addr[3:1]);
        if (c < NUM_CHIPS) begin
          if (addr[0]) r.rdata = irq_mask[c];
          else r.rdata = ocw3[c][0] ? in_service[c] : irq_req[c];
        end
      end
      cic_pkg::KIND_LINE: begin
        c = int'(id[5:3]);
        if (c < NUM_CHIPS) begin
          if (lv) begin
            irq_req[c][id[2:0]] = 1'b1;
            arbitrate();
          end else if (icw1[c][3]) begin
            irq_req[c][id[2:0]] = 1'b0;
            arbitrate();
          end
        end
      end
      cic_pkg::KIND_ACK: begin
        c   = int'(ack_chip);
        lvl = ack_level;
        if (c < NUM_CHIPS) begin
          in_service[c][lvl] = 1'b1;
          irq_req[c][lvl]    = 1'b0;
          if (c > 0) begin
            pin = icw3[c][2:0];
            in_service[c-1][pin] = 1'b1;
            irq_req[c-1][pin]    = 1'b0;
          end
          if (icw4[c][0]) begin
            r.vec = {16'd0, (icw2[c] & 8'hf8) | {5'd0, lvl}};
          end else begin
            if (icw1[c][2]) low_addr = (icw1[c] & 8'he0) | {3'd0, lvl, 2'd0};
            else low_addr = (icw1[c] & 8'hc0) | {2'd0, lvl, 3'd0};
            r.vec = {icw2[c], low_addr, cic_pkg::CALL_OPCODE};
          end
          if (icw4[c][1]) in_service[c][lvl] = 1'b0;
          arbitrate();
        end
      end
      cic_pkg::KIND_QUERY: begin
        c = int'(id[5:3]);
        if (c < NUM_CHIPS) r.rdata = {7'd0, irq_req[c][id[2:0]]};
      end
      default: ;
    endcase
    r.intr = cpu_irq;
    return r;
  endfunction

  function automatic void flag_field(input string name, input logic [23:0] want,
                                     input logic [23:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    bus_reply_t want;
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHIPS; c++) begin
        irq_mask[c]    = 8'hff;
        irq_req[c]     = '0;
        in_service[c]  = '0;
        prio_base[c]   = '0;
        icw1[c]        = '0;
        icw2[c]        = '0;
        icw3[c]        = '0;
        icw4[c]        = '0;
        ocw3[c]        = '0;
        init_expect[c] = '0;
      end
      ack_chip  = '0;
      ack_level = '0;
      cpu_irq   = 1'b0;
      due_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_replies.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected, got read_data %0h vector %0h intr %0b",
                   $time, out_read_data, out_vector, out_intr_line);
        end else begin
          want = due_replies.pop_front();
          flag_field("read_data", 24'(want.rdata), 24'(out_read_data));
          flag_field("vector", want.vec, out_vector);
          flag_field("intr_line", 24'(want.intr), 24'(out_intr_line));
        end
      end
      if (in_valid && in_ready)
        due_replies.push_back(apply_event(in_kind, in_port_addr, in_write_data,
                                          in_irq_id, in_line_level));
    end
    waiting <= due_replies.size();
  end

endmodule

### tb/tb.sv
module tb;

  localparam int NCHIP       = cic_pkg::NUM_CHIPS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  localparam logic [7:0] ICW1_FLAG   = 8'h10;
  localparam logic [7:0] ICW1_IC4    = 8'h01;
  localparam logic [7:0] ICW1_SNGL   = 8'h02;
  localparam logic [7:0] ICW1_ADI    = 8'h04;
  localparam logic [7:0] ICW1_LEVEL  = 8'h08;
  localparam logic [7:0] ICW4_UPM    = 8'h01;
  localparam logic [7:0] ICW4_AEOI   = 8'h02;
  localparam logic [7:0] ICW4_MASTER = 8'h10;
  localparam logic [7:0] OCW3_FLAG   = 8'h08;
  localparam logic [7:0] OCW3_RIS    = 8'h01;
  localparam logic [7:0] OCW3_RR     = 8'h02;
  localparam logic [7:0] OCW3_POLL   = 8'h04;
  localparam logic [7:0] OCW3_SMM    = 8'h20;
  localparam logic [7:0] OCW3_ESMM   = 8'h40;
  localparam logic [7:0] EOI_FLAG    = 8'h20;
  localparam logic [7:0] SPECIFIC    = 8'h40;
  localparam logic [7:0] ROTATE      = 8'h80;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_kind;
  logic [3:0]  in_port_addr;
  logic [7:0]  in_write_data;
  logic [5:0]  in_irq_id;
  logic        in_line_level;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_read_data;
  logic [23:0] out_vector;
  logic        out_intr_line;
  int          fails;
  int          waiting;

  bit         calm = 1'b0;
  bit         long_hold = 1'b0;
  bit         hold_done = 1'b0;
  int         sent = 0;
  logic [2:0] slave_pin = 3'd2;

  cascaded_interrupt_controller #(.NUM_CHIPS(NCHIP)) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_port_addr  (in_port_addr),
    .in_write_data (in_write_data),
    .in_irq_id     (in_irq_id),
    .in_line_level (in_line_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_vector    (out_vector),
    .out_intr_line (out_intr_line)
  );

  cic_checker #(.NUM_CHIPS(NCHIP)) u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_port_addr  (in_port_addr),
    .in_write_data (in_write_data),
    .in_irq_id     (in_irq_id),
    .in_line_level (in_line_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_vector    (out_vector),
    .out_intr_line (out_intr_line),
    .fails         (fails),
    .waiting       (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("[cascaded_interrupt_controller] ERROR");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, none once calm.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send(input logic [2:0] kind, input logic [3:0] addr, input logic [7:0] d,
                      input logic [5:0] id, input logic lv);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_port_addr  <= addr;
    in_write_data <= d;
    in_irq_id     <= id;
    in_line_level <= lv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_port(input logic [3:0] addr, input logic [7:0] d);
    send(cic_pkg::KIND_WRITE, addr, d, 6'($urandom), 1'($urandom));
  endtask

  task automatic read_port(input logic [3:0] addr);
    send(cic_pkg::KIND_READ, addr, 8'($urandom), 6'($urandom), 1'($urandom));
  endtask

  task automatic drive_line(input logic [5:0] id, input logic lv);
    send(cic_pkg::KIND_LINE, 4'($urandom), 8'($urandom), id, lv);
  endtask

  task automatic acknowledge();
    send(cic_pkg::KIND_ACK, 4'($urandom), 8'($urandom), 6'($urandom), 1'($urandom));
  endtask

  task automatic query_line(input logic [5:0] id);
    send(cic_pkg::KIND_QUERY, 4'($urandom), 8'($urandom), id, 1'($urandom));
  endtask

  task automatic program_chip(input logic [2:0] chip, input logic [7:0] w1, input logic [7:0] w2,
                              input logic [7:0] w3, input logic [7:0] w4);
    write_port({chip, 1'b0}, w1);
    write_port({chip, 1'b1}, w2);
    if (!w1[1]) write_port({chip, 1'b1}, w3);
    if (w1[0]) write_port({chip, 1'b1}, w4);
  endtask

  function automatic logic [2:0] pick_chip();
    if ($urandom_range(0, 9) == 0) return 3'($urandom);
    return 3'($urandom_range(0, NCHIP - 1));
  endfunction

  // Mostly a coherent master/slave pair, otherwise arbitrary init words.
  task automatic random_program(input logic [2:0] chip);
    logic [7:0] w1;
    logic [7:0] w2;
    logic [7:0] w3;
    logic [7:0] w4;
    bit         tidy;
    w1   = ICW1_FLAG | (8'($urandom) & ~ICW1_FLAG);
    w2   = 8'($urandom);
    w3   = 8'($urandom);
    w4   = 8'($urandom);
    tidy = NCHIP > 1 && $urandom_range(0, 3) != 0;
    if (tidy && chip == 3'd0) begin
      if ($urandom_range(0, 2) == 0) slave_pin = 3'($urandom);
      w1 = (w1 & ~ICW1_SNGL) | ICW1_IC4;
      w3 = 8'd1 << slave_pin;
      w4 = w4 | ICW4_MASTER;
    end
    if (tidy && chip == 3'd1) begin
      w1 = w1 & ~ICW1_SNGL;
      w3 = {5'd0, slave_pin};
    end
    program_chip(chip, w1, w2, w3, w4);
  endtask

  initial begin
    int pick;
    logic [7:0] w;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_kind       <= cic_pkg::KIND_WRITE;
    in_port_addr  <= '0;
    in_write_data <= '0;
    in_irq_id     <= '0;
    in_line_level <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    read_port(4'd1);
    acknowledge();
    program_chip(3'd0, ICW1_FLAG | ICW1_IC4, 8'hff, 8'h04, ICW4_UPM | ICW4_MASTER);
    program_chip(3'd1, ICW1_FLAG | ICW1_IC4 | ICW1_ADI | ICW1_LEVEL, 8'h70, 8'h02, ICW4_AEOI);
    drive_line(6'd15, 1'b1);
    acknowledge();
    drive_line(6'd0, 1'b1);
    acknowledge();
    write_port(4'd0, OCW3_FLAG | OCW3_RR | OCW3_RIS);
    read_port(4'd0);
    write_port(4'd0, EOI_FLAG);
    write_port(4'd0, ROTATE | SPECIFIC | EOI_FLAG | 8'd2);
    write_port(4'd0, EOI_FLAG);
    write_port(4'd0, OCW3_FLAG | OCW3_ESMM | OCW3_SMM | OCW3_POLL);
    drive_line(6'd15, 1'b0);
    write_port(4'd3, 8'hff);
    write_port(4'd15, 8'hff);
    read_port(4'd14);
    drive_line(6'd63, 1'b1);
    query_line(6'd63);
    send(cic_pkg::KIND_QUERY + 3'd3, 4'($urandom), 8'($urandom), 6'($urandom), 1'($urandom));

    // random
    random_program(3'd0);
    if (NCHIP > 1) random_program(3'd1);
    while (sent < 1025) begin
      if (!hold_done && sent >= 300) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (sent >= 875) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        random_program(pick_chip());
      end else if (pick < 30) begin
        drive_line({pick_chip(), 3'($urandom)}, $urandom_range(0, 4) < 3);
      end else if (pick < 45) begin
        acknowledge();
      end else if (pick < 57) begin
        w = 8'($urandom) & ~(ICW1_FLAG | OCW3_FLAG);
        if ($urandom_range(0, 3) != 0) w = w | EOI_FLAG;
        write_port({pick_chip(), 1'b0}, w);
      end else if (pick < 65) begin
        w = 8'($urandom);
        if ($urandom_range(0, 2) != 0) w = w & 8'($urandom) & 8'($urandom);
        write_port({pick_chip(), 1'b1}, w);
      end else if (pick < 73) begin
        read_port({pick_chip(), 1'($urandom)});
      end else if (pick < 78) begin
        write_port({pick_chip(), 1'b0}, (8'($urandom) & ~ICW1_FLAG) | OCW3_FLAG);
      end else if (pick < 88) begin
        query_line({pick_chip(), 3'($urandom)});
      end else begin
        send(3'($urandom), 4'($urandom), 8'($urandom), 6'($urandom), 1'($urandom));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0 && waiting == 0) begin
      $display("[cascaded_interrupt_controller] OK");
    end else begin
      $display("[cascaded_interrupt_controller] ERROR");
    end
    $finish;
  end

endmodule
